@@ hdl/phf_pkg.sv @@
// Package for the projected histogram feature block: field widths, register
// indexes, reset values and the command and status records that join the
// controller to the datapath. Depends on nothing.
`default_nettype none

package phf_pkg;

  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 6;
  localparam int POS_W      = 5;
  localparam int CNT_W      = 6;
  localparam int VAL_W      = 17;
  localparam int IDX_W      = 6;
  localparam int TOTAL_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int REM_W      = 7;

  localparam int FRAC_BITS      = 16;
  localparam int DIV_BITS_CYCLE = 4;
  localparam int DIV_CYCLES     = FRAC_BITS / DIV_BITS_CYCLE;
  localparam int STEP_W         = 2;

  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [PIX_W-1:0]  THRESHOLD_RST = 8'd20;
  localparam logic [SIZE_W-1:0] WIDTH_RST     = 6'd20;
  localparam logic [SIZE_W-1:0] HEIGHT_RST    = 6'd20;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic feat_start;
    logic div_load;
    logic div_step;
    logic feat_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_pixel;
    logic scan_done;
    logic feat_last;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/phf_ctrl.sv @@
// Controller for the projected histogram feature block: sequences pixel
// requests, the maximum scan and the per-feature division and emission.
// Depends on phf_pkg.
`default_nettype none

module phf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire phf_pkg::sts_t sts_i,
  output phf_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               result_valid_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_STEP = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [phf_pkg::STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.last_pixel) begin
            cmd_o.scan_start = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.feat_start = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d = '0;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == phf_pkg::STEP_W'(phf_pkg::DIV_CYCLES - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.feat_last) begin
          cmd_o.clear = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.feat_next = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_EMIT);

endmodule

`default_nettype wire

@@ hdl/phf_datapath.sv @@
// Datapath for the projected histogram feature block: configuration registers,
// column and row counters, maximum scan and a four-bit-per-cycle divider.
// Depends on phf_pkg.
`default_nettype none

module phf_datapath #(
  parameter int MAX_WIDTH  = phf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = phf_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [phf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [phf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [phf_pkg::PIX_W-1:0]       pixel_i,
  input  wire logic                            first_pixel_i,
  input  wire phf_pkg::cmd_t                   cmd_i,
  output phf_pkg::sts_t                        sts_o,
  output logic [phf_pkg::VAL_W-1:0]            feature_value_o,
  output logic [phf_pkg::IDX_W-1:0]            feature_index_o,
  output logic                                 is_row_feature_o,
  output logic                                 last_feature_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW = phf_pkg::SIZE_W;
  localparam int NW = phf_pkg::CNT_W;

  logic [phf_pkg::PIX_W-1:0] thr_q;
  logic [SW-1:0]             width_q, height_q;
  logic [SW-1:0]             w, h;

  logic [phf_pkg::POS_W-1:0] col_pos_q, col_pos_d, row_pos_q, row_pos_d;
  logic [NW-1:0]             col_cnt_q [MAX_WIDTH];
  logic [NW-1:0]             col_cnt_d [MAX_WIDTH];
  logic [NW-1:0]             row_cnt_q [MAX_HEIGHT];
  logic [NW-1:0]             row_cnt_d [MAX_HEIGHT];

  logic [SW-1:0] col0, row0, col_a, row_a, row_b, col_c;
  logic          wrap, hit;
  logic          last_pix, scan_done, feat_last;

  logic [phf_pkg::IDX_W-1:0] scan_q, feat_q;
  logic [NW-1:0]             cmax_q, rmax_q;
  logic [SW-1:0]             scan_len;
  logic                      is_row;
  logic [phf_pkg::IDX_W-1:0] row_off;
  logic [CW-1:0]             col_addr;
  logic [RW-1:0]             row_addr;
  logic [NW-1:0]             col_rd, row_rd, cnt_sel, den_sel;
  logic [phf_pkg::TOTAL_W-1:0] total;

  logic [phf_pkg::REM_W-1:0]  rem_q, rem_n;
  logic [NW-1:0]              den_q;
  logic [phf_pkg::VAL_W-1:0]  quo_q;
  logic                       zero_q;
  logic [phf_pkg::DIV_BITS_CYCLE-1:0] bits_n;

  // Sizes out of range are taken as the nearest legal size.
  always_comb begin
    w = width_q;
    if (width_q == '0) w = SW'(1);
    else if (width_q > SW'(MAX_WIDTH)) w = SW'(MAX_WIDTH);
    h = height_q;
    if (height_q == '0) h = SW'(1);
    else if (height_q > SW'(MAX_HEIGHT)) h = SW'(MAX_HEIGHT);
  end

  // Pixel placement, including the cases where the size changed mid-image.
  always_comb begin
    col0  = first_pixel_i ? '0 : {1'b0, col_pos_q};
    row0  = first_pixel_i ? '0 : {1'b0, row_pos_q};
    wrap  = (col0 >= w);
    col_a = wrap ? '0 : col0;
    row_a = row0 + SW'(wrap);
    row_b = (row_a >= h) ? (h - SW'(1)) : row_a;
    col_c = col_a + SW'(1);
    hit   = (pixel_i > thr_q);
    last_pix = !((col_c < w) || ((row_b + SW'(1)) < h));
  end

  always_comb begin
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (cmd_i.clear) begin
      col_pos_d = '0;
      row_pos_d = '0;
      for (int j = 0; j < MAX_WIDTH; j++) col_cnt_d[j] = '0;
      for (int j = 0; j < MAX_HEIGHT; j++) row_cnt_d[j] = '0;
    end else if (cmd_i.accept) begin
      for (int j = 0; j < MAX_WIDTH; j++) begin
        col_cnt_d[j] = first_pixel_i ? '0 : col_cnt_q[j];
        if (hit && (col_a == SW'(j))) col_cnt_d[j] = col_cnt_d[j] + NW'(1);
      end
      for (int j = 0; j < MAX_HEIGHT; j++) begin
        row_cnt_d[j] = first_pixel_i ? '0 : row_cnt_q[j];
        if (hit && (row_b == SW'(j))) row_cnt_d[j] = row_cnt_d[j] + NW'(1);
      end
      if (col_c >= w) begin
        col_pos_d = '0;
        row_pos_d = phf_pkg::POS_W'(row_b + SW'(1));
      end else begin
        col_pos_d = phf_pkg::POS_W'(col_c);
        row_pos_d = phf_pkg::POS_W'(row_b);
      end
    end
  end

  // Histogram reads: the scan index during the maximum search, the feature
  // index while a division is loaded.
  always_comb begin
    scan_len = (w > h) ? w : h;
    scan_done = ((scan_q + SW'(1)) >= scan_len);
    total   = phf_pkg::TOTAL_W'(w) + phf_pkg::TOTAL_W'(h);
    is_row  = (feat_q >= w);
    row_off = feat_q - w;
    feat_last = ((phf_pkg::TOTAL_W'(feat_q) + phf_pkg::TOTAL_W'(1)) == total);
    col_addr = cmd_i.div_load ? feat_q[CW-1:0] : scan_q[CW-1:0];
    row_addr = cmd_i.div_load ? row_off[RW-1:0] : scan_q[RW-1:0];
    col_rd   = col_cnt_q[col_addr];
    row_rd   = row_cnt_q[row_addr];
    cnt_sel  = is_row ? row_rd : col_rd;
    den_sel  = is_row ? rmax_q : cmax_q;
  end

  assign sts_o = '{last_pixel: last_pix, scan_done: scan_done, feat_last: feat_last};

  // Four restoring division steps per cycle.
  always_comb begin
    rem_n  = rem_q;
    bits_n = '0;
    for (int k = 0; k < phf_pkg::DIV_BITS_CYCLE; k++) begin
      rem_n = {rem_n[phf_pkg::REM_W-2:0], 1'b0};
      if (rem_n >= {1'b0, den_q}) begin
        rem_n = rem_n - {1'b0, den_q};
        bits_n[phf_pkg::DIV_BITS_CYCLE-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= phf_pkg::THRESHOLD_RST;
      width_q   <= phf_pkg::WIDTH_RST;
      height_q  <= phf_pkg::HEIGHT_RST;
      col_pos_q <= '0;
      row_pos_q <= '0;
      for (int j = 0; j < MAX_WIDTH; j++) col_cnt_q[j] <= '0;
      for (int j = 0; j < MAX_HEIGHT; j++) row_cnt_q[j] <= '0;
      scan_q    <= '0;
      feat_q    <= '0;
      cmax_q    <= '0;
      rmax_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          phf_pkg::REG_THRESHOLD: thr_q    <= cfg_data_i;
          phf_pkg::REG_WIDTH:     width_q  <= cfg_data_i[SW-1:0];
          phf_pkg::REG_HEIGHT:    height_q <= cfg_data_i[SW-1:0];
          default: ;
        endcase
      end
      col_pos_q <= col_pos_d;
      row_pos_q <= row_pos_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      if (cmd_i.scan_start) begin
        scan_q <= '0;
        cmax_q <= '0;
        rmax_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + phf_pkg::IDX_W'(1);
        if ((scan_q < w) && (col_rd > cmax_q)) cmax_q <= col_rd;
        if ((scan_q < h) && (row_rd > rmax_q)) rmax_q <= row_rd;
      end
      if (cmd_i.feat_start) begin
        feat_q <= '0;
      end else if (cmd_i.feat_next) begin
        feat_q <= feat_q + phf_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      den_q  <= den_sel;
      zero_q <= (den_sel == '0);
      if (cnt_sel >= den_sel) begin
        rem_q <= phf_pkg::REM_W'(cnt_sel - den_sel);
        quo_q <= phf_pkg::VAL_W'(1);
      end else begin
        rem_q <= phf_pkg::REM_W'(cnt_sel);
        quo_q <= '0;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= rem_n;
      quo_q <= {quo_q[phf_pkg::VAL_W-phf_pkg::DIV_BITS_CYCLE-1:0], bits_n};
    end
  end

  assign feature_value_o  = zero_q ? '0 : quo_q;
  assign feature_index_o  = feat_q;
  assign is_row_feature_o = is_row;
  assign last_feature_o   = feat_last;

endmodule

`default_nettype wire

@@ hdl/projected_histogram_features.sv @@
// Top level of the projected histogram feature block: joins the controller
// and the datapath and holds the interface checks. Depends on phf_pkg,
// phf_ctrl and phf_datapath.
//
//   Channel   Handshake                  Payload
//   pixel     start, busy                pixel_i, first_pixel_i
//   result    result_valid_o (strobe)    feature_value_o, feature_index_o,
//                                        is_row_feature_o, last_feature_o
//   config    cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// A pixel request that does not complete an image leaves the block idle.
// The final pixel starts a scan of max(width, height) entries for both maxima,
// then each of the width + height features is loaded, stepped and emitted by
// the shared divider, which resolves four quotient bits per cycle.
// busy is high from the final pixel until the last feature has been shown.
// Reset clears all counts and positions at once and loads the register defaults.
// Results are strobed for a single cycle; the receiver cannot stall them.
`default_nettype none

module projected_histogram_features #(
  parameter int MAX_WIDTH  = phf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = phf_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [phf_pkg::PIX_W-1:0]       pixel_i,
  input  wire logic                            first_pixel_i,
  output logic                                 result_valid_o,
  output logic [phf_pkg::VAL_W-1:0]            feature_value_o,
  output logic [phf_pkg::IDX_W-1:0]            feature_index_o,
  output logic                                 is_row_feature_o,
  output logic                                 last_feature_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [phf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [phf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  phf_pkg::cmd_t cmd;
  phf_pkg::sts_t sts;

  assign cfg_ready_o = !busy;

  phf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  phf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pixel_i          (pixel_i),
    .first_pixel_i    (first_pixel_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .feature_value_o  (feature_value_o),
    .feature_index_o  (feature_index_o),
    .is_row_feature_o (is_row_feature_o),
    .last_feature_o   (last_feature_o)
  );

  // A result is only ever shown while the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // A normalised value never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (feature_value_o <= phf_pkg::VAL_W'(1 << phf_pkg::FRAC_BITS)))
    else $error("feature value above one");

  // The final feature of an image returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_feature_o) |=> !busy)
    else $error("block still busy after final feature");

  // Results are never shown on two consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

endmodule

`default_nettype wire

@@ tb/sv/phf_checker.sv @@
`timescale 1ns / 100ps
// Checker for projected_histogram_features: watches the pixel, config and result channels,
// predicts the column and row features of each image and compares them in order.
// Depends on phf_pkg.
module phf_checker #(
  parameter int MAX_WIDTH  = phf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = phf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [phf_pkg::PIX_W-1:0]         pixel_i,
  input  logic                              first_pixel_i,
  input  logic                              result_valid_i,
  input  logic [phf_pkg::VAL_W-1:0]         feature_value_i,
  input  logic [phf_pkg::IDX_W-1:0]         feature_index_i,
  input  logic                              is_row_feature_i,
  input  logic                              last_feature_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [phf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [phf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  import phf_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             is_row;
    logic             last;
  } feature_t;

  feature_t          expected_features[$];
  logic [PIX_W-1:0]  threshold;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [CNT_W-1:0]  column_hist[MAX_WIDTH];
  logic [CNT_W-1:0]  row_hist[MAX_HEIGHT];
  logic [POS_W-1:0]  column_pos;
  logic [POS_W-1:0]  row_pos;
  int unsigned       errors = 0;

  function automatic int unsigned size_in_use(input logic [SIZE_W-1:0] v,
                                              input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] fraction(input int unsigned count,
                                                input int unsigned peak);
    if (peak == 0) return '0;
    return VAL_W'((count << FRAC_BITS) / peak);
  endfunction

  task automatic clear_histograms();
    for (int i = 0; i < MAX_WIDTH; i++) column_hist[i] = '0;
    for (int i = 0; i < MAX_HEIGHT; i++) row_hist[i] = '0;
    column_pos = '0;
    row_pos    = '0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_THRESHOLD: threshold = data[PIX_W-1:0];
      REG_WIDTH:     width_reg = data[SIZE_W-1:0];
      REG_HEIGHT:    height_reg = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic accumulate_pixel(input logic [PIX_W-1:0] pix, input logic first);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    int unsigned col_peak;
    int unsigned row_peak;
    feature_t    f;
    w = size_in_use(width_reg, MAX_WIDTH);
    h = size_in_use(height_reg, MAX_HEIGHT);
    if (first) clear_histograms();
    col = column_pos;
    row = row_pos;
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = h - 1;
    if (pix > threshold) begin
      column_hist[col] = column_hist[col] + 1'b1;
      row_hist[row]    = row_hist[row] + 1'b1;
    end
    if (col + 1 < w || row + 1 < h) begin
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      column_pos = col[POS_W-1:0];
      row_pos    = row[POS_W-1:0];
    end else begin
      col_peak = 0;
      row_peak = 0;
      for (int i = 0; i < w; i++) if (column_hist[i] > col_peak) col_peak = column_hist[i];
      for (int i = 0; i < h; i++) if (row_hist[i] > row_peak) row_peak = row_hist[i];
      for (int i = 0; i < w; i++) begin
        f.value  = fraction(column_hist[i], col_peak);
        f.index  = IDX_W'(i);
        f.is_row = 1'b0;
        f.last   = 1'b0;
        expected_features.insert(expected_features.size(), f);
      end
      for (int i = 0; i < h; i++) begin
        f.value  = fraction(row_hist[i], row_peak);
        f.index  = IDX_W'(w + i);
        f.is_row = 1'b1;
        f.last   = (i + 1 == h);
        expected_features.insert(expected_features.size(), f);
      end
      clear_histograms();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    feature_t want;
    if (!rst_ni) begin
      threshold  = THRESHOLD_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      clear_histograms();
      expected_features.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_features.size() == 0) begin
          $error("unexpected feature: index %0d, value %0d", feature_index_i, feature_value_i);
          errors++;
        end else begin
          want = expected_features.pop_front();
          if (feature_value_i !== want.value) begin
            $error("feature_value: expected %0d, actual %0d", want.value, feature_value_i);
            errors++;
          end
          if (feature_index_i !== want.index) begin
            $error("feature_index: expected %0d, actual %0d", want.index, feature_index_i);
            errors++;
          end
          if (is_row_feature_i !== want.is_row) begin
            $error("is_row_feature: expected %0d, actual %0d", want.is_row, is_row_feature_i);
            errors++;
          end
          if (last_feature_i !== want.last) begin
            $error("last_feature: expected %0d, actual %0d", want.last, last_feature_i);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (start_i && !busy_i) accumulate_pixel(pixel_i, first_pixel_i);
    end
    pending_o    <= expected_features.size();
    fail_count_o <= errors;
  end

endmodule

@@ tb/sv/tb_projected_histogram_features.sv @@
`timescale 1ns / 100ps
// Testbench top for projected_histogram_features: drives directed and random images and
// register writes, and gives the verdict from the failure count of phf_checker.
// Depends on phf_pkg, phf_checker and the block itself.
module tb_projected_histogram_features;
  import phf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  first_pixel = 1'b0;
  logic                  result_valid;
  logic [VAL_W-1:0]      feature_value;
  logic [IDX_W-1:0]      feature_index;
  logic                  is_row_feature;
  logic                  last_feature;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           stall_cycles = 0;

  int unsigned      cur_w = WIDTH_RST;
  int unsigned      cur_h = HEIGHT_RST;
  logic [PIX_W-1:0] cur_thr = THRESHOLD_RST;
  bit               no_idle = 1'b0;

  projected_histogram_features u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start),
    .busy             (busy),
    .pixel_i          (pixel),
    .first_pixel_i    (first_pixel),
    .result_valid_o   (result_valid),
    .feature_value_o  (feature_value),
    .feature_index_o  (feature_index),
    .is_row_feature_o (is_row_feature),
    .last_feature_o   (last_feature),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  phf_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .pixel_i          (pixel),
    .first_pixel_i    (first_pixel),
    .result_valid_i   (result_valid),
    .feature_value_i  (feature_value),
    .feature_index_i  (feature_index),
    .is_row_feature_i (is_row_feature),
    .last_feature_i   (last_feature),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned size_in_use(input logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return CFG_DATA_W'($urandom_range(6, 1));
    if (r < 78) return CFG_DATA_W'($urandom_range(16, 7));
    if (r < 84) return CFG_DATA_W'($urandom_range(3) << SIZE_W);
    if (r < 90) return CFG_DATA_W'(32);
    return CFG_DATA_W'($urandom_range(255, 33));
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int v;
    if ($urandom_range(1) == 0) return PIX_W'($urandom_range(255));
    v = int'(cur_thr) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
    int unsigned gap;
    start       <= 1'b1;
    pixel       <= pix;
    first_pixel <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_THRESHOLD: cur_thr = data[PIX_W-1:0];
      REG_WIDTH:     cur_w = size_in_use(data[SIZE_W-1:0]);
      REG_HEIGHT:    cur_h = size_in_use(data[SIZE_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] thr,
                           input logic [CFG_DATA_W-1:0] w,
                           input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned random_pixels;
    int unsigned n;
    random_pixels = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // One-pixel images at the threshold extremes.
    configure(8'd0, 8'd1, 8'd1);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd1, 1'b0);
    wait_drain();
    write_reg(REG_THRESHOLD, 8'd255);
    write_reg(REG_UNUSED, 8'hA5);
    send_pixel(8'd255, 1'b1);
    wait_drain();

    // Three by three image giving counts 3, 2 and 1 in both histograms.
    configure(8'd20, 8'd3, 8'd3);
    send_pixel(8'd21, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd21, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd21, 1'b0);
    send_pixel(8'd20, 1'b0);
    send_pixel(8'd21, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd20, 1'b0);
    wait_drain();

    // Width shrunk mid-image, so the pixel wraps into a row past the end.
    configure(8'd20, 8'd2, 8'd2);
    send_pixel(8'd100, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd100, 1'b0);
    wait_drain();
    write_reg(REG_WIDTH, 8'd1);
    send_pixel(8'd100, 1'b0);
    wait_drain();

    // Height shrunk mid-image, so later pixels fall into the last row.
    configure(8'd20, 8'd2, 8'd3);
    send_pixel(8'd50, 1'b1);
    send_pixel(8'd50, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd50, 1'b0);
    wait_drain();
    write_reg(REG_HEIGHT, 8'd1);
    send_pixel(8'd50, 1'b0);
    send_pixel(8'd50, 1'b0);
    wait_drain();

    // Zero sizes are taken as one.
    configure(8'd20, 8'd0, 8'hC0);
    send_pixel(8'd128, 1'b1);
    wait_drain();

    while (random_pixels < 64) begin
      no_idle = ($urandom_range(3) == 0);
      if ($urandom_range(2) == 0) write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(255)));
      if ($urandom_range(2) == 0) write_reg(REG_WIDTH, pick_size());
      if ($urandom_range(2) == 0) write_reg(REG_HEIGHT, pick_size());
      if ($urandom_range(15) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(255)));
      if (cur_w * cur_h > 64) begin
        if (cur_w > cur_h) begin
          write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(2, 1)));
        end else begin
          write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(2, 1)));
        end
      end
      if ($urandom_range(3) != 0) begin
        repeat ($urandom_range(2, 1)) begin
          for (int p = 0; p < cur_w * cur_h; p++) begin
            send_pixel(pick_pixel(), p == 0);
            random_pixels++;
          end
        end
      end else begin
        n = $urandom_range(cur_w * cur_h + 2, 1);
        repeat (n) begin
          send_pixel(pick_pixel(), $urandom_range(3) == 0);
          random_pixels++;
        end
      end
      wait_drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
